// ===== hdl/mwoc_pkg.sv =====
// Shared types and constants for the multi-word occurrence counter.
package mwoc_pkg;

   localparam int BYTE_W           = 8;
   localparam int COUNT_W          = 32;
   localparam int SLOT_W           = 4;
   localparam int POS_W            = 5;
   localparam int REQ_W            = 2;
   localparam int WORDS_W          = 4;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int DEF_NUM_WORDS    = 10;
   localparam int DEF_MAX_WORD_LEN = 32;

   localparam logic [WORDS_W-1:0] WORDS_RESET = 4'd10;

   // Register index decoded from the word address bit of paddr.
   localparam logic CSR_IDX_WORDS = 1'b0;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD_CHAR = 2'd0,
      REQ_SET_LEN   = 2'd1,
      REQ_TEXT      = 2'd2,
      REQ_END       = 2'd3
   } req_code_type;

   // Strobes sent from the top level to every cell of the row.
   typedef struct packed {
      logic load_char;
      logic load_len;
      logic text_byte;
      logic end_text;
      logic report_shift;
   } cell_ctrl_type;

endpackage

// ===== hdl/mwoc_cell.sv =====
// One search-word cell: pattern, length, match comparators, count and report stage.
module mwoc_cell #(
   parameter int MAX_WORD_LEN = mwoc_pkg::DEF_MAX_WORD_LEN,
   parameter int CELL_IDX     = 0
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  mwoc_pkg::cell_ctrl_type                          ctrl,
   input  logic                                             active,
   input  logic [mwoc_pkg::SLOT_W-1:0]                      word_slot,
   input  logic [mwoc_pkg::POS_W-1:0]                       char_position,
   input  logic [mwoc_pkg::BYTE_W-1:0]                      byte_value,
   input  logic [MAX_WORD_LEN-1:0][mwoc_pkg::BYTE_W-1:0]    window,
   input  logic [$clog2(MAX_WORD_LEN)-1:0]                  seen,
   input  logic [mwoc_pkg::COUNT_W-1:0]                     report_next,
   output logic [mwoc_pkg::COUNT_W-1:0]                     report
);
   import mwoc_pkg::*;

   localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
   localparam int IDX_W = $clog2(MAX_WORD_LEN);

   logic [MAX_WORD_LEN-1:0][BYTE_W-1:0] pat_ff, pat_in;
   logic [LEN_W-1:0]                    len_ff, len_in;
   logic                                match_ff, match_in;
   logic [COUNT_W-1:0]                  count_ff, count_in;
   logic [COUNT_W-1:0]                  report_ff, report_in;

   logic                    slot_hit;
   logic [MAX_WORD_LEN-1:0] hits;
   logic [IDX_W-1:0]        len_m1;
   logic                    len_ok;
   logic [COUNT_W-1:0]      count_sum;

   assign slot_hit = (word_slot == SLOT_W'(CELL_IDX));

   always_comb begin
      pat_in = pat_ff;
      for (int p = 0; p < MAX_WORD_LEN; p++) begin
         if (ctrl.load_char && slot_hit && p < (1 << POS_W) &&
             char_position == POS_W'(p)) begin
            pat_in[p] = byte_value;
         end
      end
   end

   always_comb begin
      len_in = len_ff;
      if (ctrl.load_len && slot_hit) begin
         if (byte_value > BYTE_W'(MAX_WORD_LEN)) begin
            len_in = LEN_W'(MAX_WORD_LEN);
         end else begin
            len_in = LEN_W'(byte_value);
         end
      end
   end

   // hits[l] is set when a word of length l+1 would end on the newest byte.
   always_comb begin
      logic hit;
      hits = '0;
      for (int l = 0; l < MAX_WORD_LEN; l++) begin
         hit = 1'b1;
         for (int p = 0; p <= l; p++) begin
            if (pat_ff[p] != window[l-p]) begin
               hit = 1'b0;
            end
         end
         hits[l] = hit;
      end
   end

   assign len_m1 = IDX_W'(len_ff - LEN_W'(1));
   assign len_ok = (len_ff != '0) && (len_m1 <= seen);

   assign match_in = ctrl.text_byte && active && len_ok && hits[len_m1];

   // The match found on the previous byte is folded in here, saturating.
   assign count_sum = (&count_ff) ? count_ff : count_ff + COUNT_W'(match_ff);

   always_comb begin
      count_in  = count_sum;
      report_in = report_ff;
      if (ctrl.end_text) begin
         count_in  = '0;
         report_in = count_sum;
      end else if (ctrl.report_shift) begin
         report_in = report_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         match_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         len_ff   <= len_in;
         match_ff <= match_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff    <= pat_in;
      report_ff <= report_in;
   end

   assign report = report_ff;

endmodule

// ===== hdl/multi_word_occurrence_counter.sv =====
// Top level of the multi-word occurrence counter: history, cell row, report and register port.
//
//   Channel   Direction  Handshake                 Carries
//   req_      in         req_valid / req_ready     pattern loads, text bytes, end of text
//   rsp_      out        rsp_valid / rsp_ready     one count per word in use at end of text
//   csr_      in/out     psel penable pwrite ...   words_in_use at byte address 0
//
// Every load and text word is taken as soon as it is offered, one per clock, whatever the
// state of the result channel. Matching for a text byte happens in the cycle it is
// accepted; the match is registered in each cell's match_ff and then added into its count_ff.
// An end-of-text word is held off only while an earlier report is still draining;
// a report of n counts drains through the report chain, one count per word taken.
// Reset is synchronous and clears lengths, counts, byte count and report state.
module multi_word_occurrence_counter #(
   parameter int NUM_WORDS    = mwoc_pkg::DEF_NUM_WORDS,
   parameter int MAX_WORD_LEN = mwoc_pkg::DEF_MAX_WORD_LEN
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mwoc_pkg::REQ_W-1:0]         req_type,
   input  logic [mwoc_pkg::SLOT_W-1:0]        req_word_slot,
   input  logic [mwoc_pkg::POS_W-1:0]         req_char_position,
   input  logic [mwoc_pkg::BYTE_W-1:0]        req_byte_value,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mwoc_pkg::SLOT_W-1:0]        rsp_word_number,
   output logic [mwoc_pkg::COUNT_W-1:0]       rsp_match_count,
   output logic                               rsp_last_of_run,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mwoc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mwoc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mwoc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import mwoc_pkg::*;

   localparam int IDX_W = $clog2(MAX_WORD_LEN);
   localparam int CNT_W = $clog2(NUM_WORDS + 1);

   // Registers.
   logic [WORDS_W-1:0]                    words_ff, words_in;
   logic [IDX_W-1:0]                      seen_ff, seen_in;
   logic [MAX_WORD_LEN-2:0][BYTE_W-1:0]   hist_ff, hist_in;
   logic [CNT_W-1:0]                      rsp_left_ff, rsp_left_in;
   logic [SLOT_W-1:0]                     rsp_idx_ff, rsp_idx_in;

   // Combinational signals.
   req_code_type                          req_code;
   logic                                  req_fire;
   logic                                  rsp_fire;
   logic                                  csr_write;
   logic [CNT_W-1:0]                      n_eff;
   logic [NUM_WORDS-1:0]                  active;
   logic [MAX_WORD_LEN-1:0][BYTE_W-1:0]   window;
   cell_ctrl_type                         ctrl;
   logic [NUM_WORDS:0][COUNT_W-1:0]       reports;

   assign req_code = req_code_type'(req_type);

   // A new end of text would overwrite the report chain, so it waits for the drain.
   assign req_ready = !(req_code == REQ_END && rsp_left_ff != '0);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      ctrl.load_char    = req_fire && (req_code == REQ_LOAD_CHAR);
      ctrl.load_len     = req_fire && (req_code == REQ_SET_LEN);
      ctrl.text_byte    = req_fire && (req_code == REQ_TEXT);
      ctrl.end_text     = req_fire && (req_code == REQ_END);
      ctrl.report_shift = rsp_fire;
   end

   // A register value above the number of cells behaves as the number of cells.
   assign n_eff = ({1'b0, words_ff} > (WORDS_W + 1)'(NUM_WORDS)) ? CNT_W'(NUM_WORDS)
                                                                : CNT_W'(words_ff);

   always_comb begin
      for (int w = 0; w < NUM_WORDS; w++) begin
         active[w] = (CNT_W'(w) < n_eff);
      end
   end

   // The comparison window is the byte being accepted followed by the stored history,
   // newest first. History entries beyond the byte count are never relied upon,
   // because each cell checks its length against seen_ff.
   always_comb begin
      window[0] = req_byte_value;
      for (int d = 1; d < MAX_WORD_LEN; d++) begin
         window[d] = hist_ff[d-1];
      end
   end

   always_comb begin
      hist_in = hist_ff;
      if (ctrl.text_byte) begin
         hist_in[0] = req_byte_value;
         for (int d = 1; d < MAX_WORD_LEN - 1; d++) begin
            hist_in[d] = hist_ff[d-1];
         end
      end
   end

   always_comb begin
      seen_in = seen_ff;
      if (ctrl.end_text) begin
         seen_in = '0;
      end else if (ctrl.text_byte && seen_ff < IDX_W'(MAX_WORD_LEN - 1)) begin
         seen_in = seen_ff + IDX_W'(1);
      end
   end

   // Report sequencing: the counts are captured into the cells' report stages at
   // end of text and then move one cell towards the output for each word taken.
   always_comb begin
      rsp_left_in = rsp_left_ff;
      rsp_idx_in  = rsp_idx_ff;
      if (ctrl.end_text) begin
         rsp_left_in = n_eff;
         rsp_idx_in  = '0;
      end else if (rsp_fire) begin
         rsp_left_in = rsp_left_ff - CNT_W'(1);
         rsp_idx_in  = rsp_idx_ff + SLOT_W'(1);
      end
   end

   assign rsp_valid       = (rsp_left_ff != '0);
   assign rsp_word_number = rsp_idx_ff;
   assign rsp_match_count = reports[0];
   assign rsp_last_of_run = (rsp_left_ff == CNT_W'(1));

   // Register port: a single register, words_in_use, at byte address zero.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      words_in = words_ff;
      if (csr_write && paddr[CSR_ADDR_W-1] == CSR_IDX_WORDS) begin
         words_in = pwdata[WORDS_W-1:0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_IDX_WORDS) ? CSR_DATA_W'(words_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff    <= WORDS_RESET;
         seen_ff     <= '0;
         rsp_left_ff <= '0;
         rsp_idx_ff  <= '0;
      end else begin
         words_ff    <= words_in;
         seen_ff     <= seen_in;
         rsp_left_ff <= rsp_left_in;
         rsp_idx_ff  <= rsp_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
   end

   // The row of cells. The far end of the report chain feeds zeros.
   assign reports[NUM_WORDS] = '0;

   for (genvar w = 0; w < NUM_WORDS; w++) begin : g_cell
      mwoc_cell #(
         .MAX_WORD_LEN (MAX_WORD_LEN),
         .CELL_IDX     (w)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .active        (active[w]),
         .word_slot     (req_word_slot),
         .char_position (req_char_position),
         .byte_value    (req_byte_value),
         .window        (window),
         .seen          (seen_ff),
         .report_next   (reports[w+1]),
         .report        (reports[w])
      );
   end

endmodule

// ===== tb/tb_multi_word_occurrence_counter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multi-word occurrence counter: directed, pressure and random tests.
module tb_multi_word_occurrence_counter;
   import mwoc_pkg::*;

   localparam int NUM_WORDS     = DEF_NUM_WORDS;
   localparam int MAX_WORD_LEN  = DEF_MAX_WORD_LEN;
   localparam int HISTORY_LEN   = MAX_WORD_LEN - 1;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 10;
   // Counts pass through match_ff and count_ff; the settle wait covers any work in flight.
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 70;
   localparam int REPORT_SHOWN  = 10;

   localparam logic [CSR_ADDR_W-1:0] WORDS_ADDR = {CSR_IDX_WORDS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = {~CSR_IDX_WORDS, 2'b00};

   localparam logic [BYTE_W-1:0] CHAR_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_B = 8'h62;
   localparam logic [BYTE_W-1:0] CHAR_Z = 8'h7a;

   // One count of an end-of-text report, as the result channel carries it.
   typedef struct packed {
      logic [SLOT_W-1:0]  word_number;
      logic [COUNT_W-1:0] match_count;
      logic               last_of_run;
   } word_report_type;

   logic                  clock = 1'b0;
   logic                  reset;

   logic                  req_valid;
   logic                  req_ready;
   req_code_type          req_type;
   logic [SLOT_W-1:0]     req_word_slot;
   logic [POS_W-1:0]      req_char_position;
   logic [BYTE_W-1:0]     req_byte_value;

   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SLOT_W-1:0]     rsp_word_number;
   logic [COUNT_W-1:0]    rsp_match_count;
   logic                  rsp_last_of_run;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // The testbench's own copy of the block's state, advanced word by word as the
   // input channel accepts them.
   logic [BYTE_W-1:0]     pattern_chars  [NUM_WORDS][MAX_WORD_LEN];
   bit                    char_loaded    [NUM_WORDS][MAX_WORD_LEN];
   int unsigned           word_length    [NUM_WORDS];
   logic [BYTE_W-1:0]     text_history   [HISTORY_LEN];
   int unsigned           history_fill;
   logic [COUNT_W-1:0]    running_counts [NUM_WORDS];
   logic [WORDS_W-1:0]    words_setting;

   // Counts still owed by the block, oldest first.
   word_report_type       pending_reports [$];

   int unsigned           mismatch_count = 0;
   int unsigned           accepted_words = 0;
   int unsigned           quiet_cycles   = 0;
   bit                    idle_enable    = 1'b1;
   bit                    hold_request   = 1'b0;

   multi_word_occurrence_counter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_word_slot     (req_word_slot),
      .req_char_position (req_char_position),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_word_number   (rsp_word_number),
      .rsp_match_count   (rsp_match_count),
      .rsp_last_of_run   (rsp_last_of_run),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   task automatic note_mismatch(input string what, input longint unsigned exp_value,
                                input longint unsigned act_value);
      mismatch_count++;
      if (mismatch_count <= REPORT_SHOWN) begin
         $display("mismatch in %s: expected %0d, got %0d", what, exp_value, act_value);
      end
   endtask

   // Advances the predicted state by one accepted word and queues any counts it causes.
   task automatic predict_word(input req_code_type kind, input logic [SLOT_W-1:0] slot,
                               input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] value);
      int unsigned     active;
      int unsigned     len;
      bit              hit;
      word_report_type entry;
      // A setting above the number of words simply means all of them.
      active = (words_setting > NUM_WORDS) ? NUM_WORDS : words_setting;
      case (kind)
         REQ_LOAD_CHAR: begin
            if (slot < NUM_WORDS) begin
               pattern_chars[slot][pos] = value;
               char_loaded[slot][pos]   = 1'b1;
            end
         end
         REQ_SET_LEN: begin
            if (slot < NUM_WORDS) begin
               word_length[slot] = (value > MAX_WORD_LEN) ? MAX_WORD_LEN : value;
            end
         end
         REQ_TEXT: begin
            for (int w = 0; w < active; w++) begin
               len = word_length[w];
               hit = 1'b0;
               // The last character lines up with the newest byte, the rest with the history.
               if (len != 0 && len <= history_fill + 1) begin
                  hit = (pattern_chars[w][len-1] == value);
                  for (int j = 1; j < len; j++) begin
                     if (pattern_chars[w][len-1-j] != text_history[j-1]) begin
                        hit = 1'b0;
                     end
                  end
               end
               if (hit && running_counts[w] != '1) begin
                  running_counts[w]++;
               end
            end
            for (int k = HISTORY_LEN - 1; k > 0; k--) begin
               text_history[k] = text_history[k-1];
            end
            text_history[0] = value;
            if (history_fill < HISTORY_LEN) begin
               history_fill++;
            end
         end
         REQ_END: begin
            for (int w = 0; w < active; w++) begin
               entry.word_number = SLOT_W'(w);
               entry.match_count = running_counts[w];
               entry.last_of_run = (w + 1 == active);
               pending_reports.push_back(entry);
            end
            // A fresh text starts: no occurrence may span the boundary.
            for (int w = 0; w < NUM_WORDS; w++) begin
               running_counts[w] = '0;
            end
            for (int k = 0; k < HISTORY_LEN; k++) begin
               text_history[k] = '0;
            end
            history_fill = 0;
         end
      endcase
   endtask

   // Offers one word after a random gap and holds it until the block takes it.
   task automatic send_word(input req_code_type kind, input logic [SLOT_W-1:0] slot,
                            input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] value);
      int unsigned gap;
      gap = idle_enable ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_word_slot     <= slot;
      req_char_position <= pos;
      req_byte_value    <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(kind, slot, pos, value);
      // Loads aimed past the last word are dropped by the block and are not counted.
      if (!((kind == REQ_LOAD_CHAR || kind == REQ_SET_LEN) && slot >= NUM_WORDS)) begin
         accepted_words++;
      end
   endtask

   function automatic logic [BYTE_W-1:0] text_byte();
      // A two-letter alphabet keeps matches frequent; the odd random byte adds noise.
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(0, 1) ? CHAR_A : CHAR_B;
      end
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic send_text_byte(input logic [BYTE_W-1:0] value);
      send_word(REQ_TEXT, SLOT_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 31)), value);
   endtask

   task automatic send_text(input int unsigned count);
      repeat (count) send_text_byte(text_byte());
   endtask

   task automatic end_text();
      send_word(REQ_END, SLOT_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 31)),
                BYTE_W'($urandom_range(0, 255)));
   endtask

   // Sets a length, first loading any character the new length would cover that has
   // never been written, so that the block never compares an unwritten entry.
   task automatic set_length(input logic [SLOT_W-1:0] slot, input logic [BYTE_W-1:0] value);
      int unsigned span;
      span = (value > MAX_WORD_LEN) ? MAX_WORD_LEN : value;
      if (slot < NUM_WORDS) begin
         for (int p = 0; p < span; p++) begin
            if (!char_loaded[slot][p]) begin
               send_word(REQ_LOAD_CHAR, slot, POS_W'(p), BYTE_W'($urandom_range(0, 255)));
            end
         end
      end
      send_word(REQ_SET_LEN, slot, POS_W'($urandom_range(0, 31)), value);
   endtask

   task automatic load_word(input logic [SLOT_W-1:0] slot, input int unsigned len);
      for (int p = 0; p < len; p++) begin
         send_word(REQ_LOAD_CHAR, slot, POS_W'(p), text_byte());
      end
      set_length(slot, BYTE_W'(len));
   endtask

   // Stops offering words until every owed count has arrived and the block is quiet.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes a register while the block is idle, then reads words_in_use back.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] value);
      drain_and_settle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == WORDS_ADDR) begin
         words_setting = value[WORDS_W-1:0];
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      paddr   <= WORDS_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== CSR_DATA_W'(words_setting)) begin
         note_mismatch("words_in_use read back", 64'(words_setting), 64'(prdata));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Byte extremes in patterns and text, a zero-length word, loads past the last word,
   // and a text boundary that would otherwise complete a word.
   task automatic test_directed_patterns();
      logic [BYTE_W-1:0] probe_bytes [6] = '{8'hFF, 8'hFF, 8'h00, CHAR_A, 8'h00, CHAR_A};
      send_word(REQ_LOAD_CHAR, 4'd0, 5'd0, 8'hFF);
      set_length(4'd0, 8'd1);
      send_word(REQ_LOAD_CHAR, 4'd1, 5'd0, CHAR_A);
      send_word(REQ_LOAD_CHAR, 4'd1, 5'd1, 8'h00);
      set_length(4'd1, 8'd2);
      send_word(REQ_LOAD_CHAR, 4'hF, 5'd31, 8'hAA);
      send_word(REQ_SET_LEN, 4'd12, 5'd0, 8'd5);
      set_length(4'd2, 8'd0);
      foreach (probe_bytes[i]) begin
         send_text_byte(probe_bytes[i]);
      end
      end_text();
      // The previous text ended in 'a'; a zero byte now must not complete word one.
      send_text_byte(8'h00);
      end_text();
   endtask

   // A full-length word reached through a saturating length, which cannot match
   // before the text holds as many bytes as the word.
   task automatic test_long_word();
      for (int p = 0; p < MAX_WORD_LEN; p++) begin
         send_word(REQ_LOAD_CHAR, 4'd3, POS_W'(p), CHAR_Z);
      end
      set_length(4'd3, 8'd255);
      set_length(4'd4, 8'd33);
      repeat (MAX_WORD_LEN + 1) send_text_byte(CHAR_Z);
      end_text();
   endtask

   // No words in use, a setting above the word count, an ignored register and a single word.
   task automatic test_words_in_use();
      load_word(4'd0, 2);
      load_word(4'd1, 1);
      write_csr(WORDS_ADDR, 32'd0);
      send_text(8);
      end_text();
      write_csr(WORDS_ADDR, 32'd15);
      send_text(8);
      end_text();
      write_csr(SPARE_ADDR, 32'd3);
      send_text(6);
      end_text();
      write_csr(WORDS_ADDR, 32'd1);
      send_text(8);
      end_text();
      write_csr(WORDS_ADDR, 32'(WORDS_RESET));
   endtask

   // The receiver holds off for a long stretch while the next end of text waits behind it,
   // then a back-to-back stretch with no idling on either side.
   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (3) begin
         send_text(6);
         end_text();
      end
      drain_and_settle();
      idle_enable = 1'b0;
      send_text(20);
      end_text();
      end_text();
      drain_and_settle();
      idle_enable = 1'b1;
   endtask

   // Rounds of reloaded words, noise, a text and its report, with settings changed between.
   task automatic test_random_texts();
      int unsigned target;
      int unsigned choice;
      target = accepted_words + RANDOM_ITEMS;
      while (accepted_words < target) begin
         idle_enable = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            choice = $urandom_range(0, 4);
            write_csr(WORDS_ADDR, (choice == 0) ? 0 : (choice == 1) ? 1 : (choice == 2) ? 15 :
                                  (choice == 3) ? 10 : $urandom_range(0, 15));
         end
         repeat ($urandom_range(1, 3)) begin
            load_word(SLOT_W'($urandom_range(0, NUM_WORDS - 1)), $urandom_range(1, 4));
         end
         if ($urandom_range(0, 7) == 0) begin
            set_length(SLOT_W'($urandom_range(0, NUM_WORDS - 1)),
                       BYTE_W'($urandom_range(0, 255)));
         end
         repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1)) begin
               send_word($urandom_range(0, 1) ? REQ_LOAD_CHAR : REQ_SET_LEN,
                         SLOT_W'($urandom_range(NUM_WORDS, 15)), POS_W'($urandom_range(0, 31)),
                         BYTE_W'($urandom_range(0, 255)));
            end else begin
               send_word(REQ_LOAD_CHAR, SLOT_W'($urandom_range(0, NUM_WORDS - 1)),
                         POS_W'($urandom_range(0, 31)), BYTE_W'($urandom_range(0, 255)));
            end
         end
         send_text($urandom_range(0, 30));
         end_text();
         if ($urandom_range(0, 5) == 0) begin
            drain_and_settle();
         end
      end
   endtask

   // Receiver: a random wait before each count, and a long hold-off when asked for one.
   initial begin
      int unsigned gap;
      rsp_ready <= 1'b0;
      wait (!reset);
      forever begin
         gap = idle_enable ? $urandom_range(0, 8) : 0;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid && !hold_request) @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
      end
   end

   // Every count taken from the block is compared with the oldest one owed.
   always @(posedge clock) begin
      word_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            note_mismatch("count with none owed, word number", 64'(0), 64'(rsp_word_number));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_word_number !== want.word_number) begin
               note_mismatch("word_number", 64'(want.word_number), 64'(rsp_word_number));
            end
            if (rsp_match_count !== want.match_count) begin
               note_mismatch("match_count", 64'(want.match_count), 64'(rsp_match_count));
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               note_mismatch("last_of_run", 64'(want.last_of_run), 64'(rsp_last_of_run));
            end
         end
      end
   end

   // Watchdog: a long run of cycles in which nothing moves on any port ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_type          <= REQ_LOAD_CHAR;
      req_word_slot     <= '0;
      req_char_position <= '0;
      req_byte_value    <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      // Predicted state after reset.
      for (int w = 0; w < NUM_WORDS; w++) begin
         for (int p = 0; p < MAX_WORD_LEN; p++) begin
            pattern_chars[w][p] = '0;
            char_loaded[w][p]   = 1'b0;
         end
         word_length[w]    = 0;
         running_counts[w] = '0;
      end
      for (int k = 0; k < HISTORY_LEN; k++) begin
         text_history[k] = '0;
      end
      history_fill  = 0;
      words_setting = WORDS_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_patterns();
      test_long_word();
      test_words_in_use();
      test_backpressure();
      test_random_texts();

      // A count that never arrives keeps this waiting until the watchdog fires.
      drain_and_settle();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
